// ===== hw/rtl/gyro_heading_pid_assert.svh =====
`ifndef GYRO_HEADING_PID_ASSERT_SVH
`define GYRO_HEADING_PID_ASSERT_SVH

// check a condition in the cycle after a trigger
`define GHP_ASSERT_NEXT(lbl, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("assertion failed");

// check a condition in the cycle of a trigger
`define GHP_ASSERT_SAME(lbl, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error("assertion failed");

`endif

// ===== hw/rtl/ghp_pkg.sv =====
package ghp_pkg;

  localparam int FRAC_BITS = 16;
  localparam int COEF_SHIFT = 28;
  localparam int INTEG_MAX = ((3 << FRAC_BITS) + 5) / 10;
  localparam int CORR_MAX = ((15 << FRAC_BITS) + 50) / 100;

  localparam logic signed [32:0] COEF_B0 = 33'sd5390989;
  localparam logic signed [32:0] COEF_B1 = 33'sd10782247;
  localparam logic signed [32:0] COEF_B2 = 33'sd5390989;
  localparam logic signed [32:0] COEF_NEG_A1 = 33'sd419032579;
  localparam logic signed [32:0] COEF_NEG_A2 = -33'sd172161617;
  localparam logic signed [32:0] HEAD_K = 33'sd749613;
  localparam logic signed [32:0] DT_K = 33'sd42949673;
  localparam logic signed [32:0] INV_DT = 33'sd100;

  localparam logic [2:0] REG_RATE_KP = 3'd0;
  localparam logic [2:0] REG_RATE_KI = 3'd1;
  localparam logic [2:0] REG_RATE_KD = 3'd2;
  localparam logic [2:0] REG_LOCK_KP = 3'd3;
  localparam logic [2:0] REG_LOCK_KI = 3'd4;
  localparam logic [2:0] REG_RATE_OFFSET = 3'd5;
  localparam logic [2:0] REG_LOCK_MODE = 3'd6;

  localparam logic signed [23:0] LOCK_KP_RESET = 24'sd131072;
  localparam logic signed [23:0] LOCK_KI_RESET = 24'sd3277;

  typedef struct packed {
    logic action;
    logic signed [31:0] yaw_rate_in;
  } sample_t;

  typedef struct packed {
    logic signed [14:0] correction;
    logic signed [31:0] filtered_rate;
    logic signed [31:0] heading_angle;
  } result_t;

  typedef struct packed {
    logic signed [23:0] rate_kp;
    logic signed [23:0] rate_ki;
    logic signed [23:0] rate_kd;
    logic signed [23:0] lock_kp;
    logic signed [23:0] lock_ki;
    logic signed [31:0] rate_offset;
    logic lock_mode;
  } cfg_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -66'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [65:0] round_shift(input logic signed [65:0] v,
                                                      input int n);
    logic signed [65:0] half;
    half = 66'sd1 <<< (n - 1);
    return (v + half) >>> n;
  endfunction

endpackage

// ===== hw/rtl/ghp_regs.sv =====
module ghp_regs (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output ghp_pkg::cfg_t     cfg
);

  logic wr;
  assign wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rate_kp <= '0;
      cfg.rate_ki <= '0;
      cfg.rate_kd <= '0;
      cfg.lock_kp <= ghp_pkg::LOCK_KP_RESET;
      cfg.lock_ki <= ghp_pkg::LOCK_KI_RESET;
      cfg.rate_offset <= '0;
      cfg.lock_mode <= 1'b0;
    end else if (wr) begin
      unique case (paddr[4:2])
        ghp_pkg::REG_RATE_KP: cfg.rate_kp <= pwdata[23:0];
        ghp_pkg::REG_RATE_KI: cfg.rate_ki <= pwdata[23:0];
        ghp_pkg::REG_RATE_KD: cfg.rate_kd <= pwdata[23:0];
        ghp_pkg::REG_LOCK_KP: cfg.lock_kp <= pwdata[23:0];
        ghp_pkg::REG_LOCK_KI: cfg.lock_ki <= pwdata[23:0];
        ghp_pkg::REG_RATE_OFFSET: cfg.rate_offset <= pwdata;
        ghp_pkg::REG_LOCK_MODE: cfg.lock_mode <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      ghp_pkg::REG_RATE_KP: prdata = {8'd0, cfg.rate_kp};
      ghp_pkg::REG_RATE_KI: prdata = {8'd0, cfg.rate_ki};
      ghp_pkg::REG_RATE_KD: prdata = {8'd0, cfg.rate_kd};
      ghp_pkg::REG_LOCK_KP: prdata = {8'd0, cfg.lock_kp};
      ghp_pkg::REG_LOCK_KI: prdata = {8'd0, cfg.lock_ki};
      ghp_pkg::REG_RATE_OFFSET: prdata = cfg.rate_offset;
      ghp_pkg::REG_LOCK_MODE: prdata = {31'd0, cfg.lock_mode};
      default: prdata = '0;
    endcase
  end

endmodule

// ===== hw/rtl/ghp_mul.sv =====
module ghp_mul (
  input  logic                clk,
  input  logic signed [32:0]  a,
  input  logic signed [32:0]  b,
  output logic signed [65:0]  prod
);

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

// ===== hw/rtl/ghp_core.sv =====
module ghp_core (
  input  logic                clk,
  input  logic                rst,
  input  ghp_pkg::cfg_t       cfg,
  input  logic                sample_valid,
  output logic                sample_stall,
  input  ghp_pkg::sample_t    sample,
  output logic                result_valid,
  input  logic                result_stall,
  output ghp_pkg::result_t    result,
  output logic signed [32:0]  mul_a,
  output logic signed [32:0]  mul_b,
  input  logic signed [65:0]  prod
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SUB  = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_ACC  = 3'd3;
  localparam logic [2:0] S_FILT = 3'd4;
  localparam logic [2:0] S_CORR = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  localparam logic [3:0] OP_B0   = 4'd0;
  localparam logic [3:0] OP_B1   = 4'd1;
  localparam logic [3:0] OP_B2   = 4'd2;
  localparam logic [3:0] OP_A1   = 4'd3;
  localparam logic [3:0] OP_A2   = 4'd4;
  localparam logic [3:0] OP_HEAD = 4'd5;
  localparam logic [3:0] OP_INTG = 4'd6;
  localparam logic [3:0] OP_KD   = 4'd7;
  localparam logic [3:0] OP_P    = 4'd8;
  localparam logic [3:0] OP_I    = 4'd9;
  localparam logic [3:0] OP_D    = 4'd10;

  localparam logic signed [65:0] INTEG_LIM = 66'(ghp_pkg::INTEG_MAX);
  localparam logic signed [65:0] CORR_LIM = 66'(ghp_pkg::CORR_MAX);

  logic [2:0] state;
  logic [3:0] op;
  logic signed [31:0] yaw;
  logic signed [31:0] x, h0, h1, y0, y1;
  logic signed [31:0] heading;
  logic signed [17:0] integ;
  logic signed [31:0] last_err;
  logic signed [32:0] diff;
  logic signed [30:0] kd100;
  logic signed [65:0] acc;
  logic signed [14:0] corr;

  logic signed [31:0] err;
  logic signed [23:0] kp_sel, ki_sel, kd_sel;
  logic signed [65:0] prod_sum;
  logic signed [65:0] head_sum;
  logic signed [65:0] integ_sum;
  logic signed [65:0] filt_rnd;
  logic signed [65:0] corr_rnd;

  assign sample_stall = rst || (state != S_IDLE);

  always_comb begin
    err = cfg.lock_mode ? ghp_pkg::sat32(-66'(heading)) : y0;
    kp_sel = cfg.lock_mode ? cfg.lock_kp : cfg.rate_kp;
    ki_sel = cfg.lock_mode ? cfg.lock_ki : cfg.rate_ki;
    kd_sel = cfg.lock_mode ? 24'sd0 : cfg.rate_kd;
    prod_sum = acc + prod;
    head_sum = 66'(heading) - ghp_pkg::round_shift(prod, 32);
    integ_sum = 66'(integ) + ghp_pkg::round_shift(prod, 32);
    if (integ_sum > INTEG_LIM) begin
      integ_sum = INTEG_LIM;
    end else if (integ_sum < -INTEG_LIM) begin
      integ_sum = -INTEG_LIM;
    end
    filt_rnd = ghp_pkg::round_shift(acc, ghp_pkg::COEF_SHIFT);
    corr_rnd = ghp_pkg::round_shift(acc, ghp_pkg::FRAC_BITS);
    if (corr_rnd > CORR_LIM) begin
      corr_rnd = CORR_LIM;
    end else if (corr_rnd < -CORR_LIM) begin
      corr_rnd = -CORR_LIM;
    end
  end

  always_comb begin
    case (op)
      OP_B0: begin
        mul_a = ghp_pkg::COEF_B0;
        mul_b = 33'(x);
      end
      OP_B1: begin
        mul_a = ghp_pkg::COEF_B1;
        mul_b = 33'(h0);
      end
      OP_B2: begin
        mul_a = ghp_pkg::COEF_B2;
        mul_b = 33'(h1);
      end
      OP_A1: begin
        mul_a = ghp_pkg::COEF_NEG_A1;
        mul_b = 33'(y0);
      end
      OP_A2: begin
        mul_a = ghp_pkg::COEF_NEG_A2;
        mul_b = 33'(y1);
      end
      OP_HEAD: begin
        mul_a = 33'(y0);
        mul_b = ghp_pkg::HEAD_K;
      end
      OP_INTG: begin
        mul_a = 33'(err);
        mul_b = ghp_pkg::DT_K;
      end
      OP_KD: begin
        mul_a = 33'(kd_sel);
        mul_b = ghp_pkg::INV_DT;
      end
      OP_P: begin
        mul_a = 33'(kp_sel);
        mul_b = 33'(err);
      end
      OP_I: begin
        mul_a = 33'(ki_sel);
        mul_b = 33'(integ);
      end
      OP_D: begin
        mul_a = 33'(kd100);
        mul_b = diff;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op <= OP_B0;
      result_valid <= 1'b0;
      h0 <= '0;
      h1 <= '0;
      y0 <= '0;
      y1 <= '0;
      heading <= '0;
      integ <= '0;
      last_err <= '0;
    end else begin
      if (result_valid && !result_stall && state != S_OUT) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (sample_valid) begin
            if (sample.action) begin
              heading <= '0;
              integ <= '0;
              last_err <= '0;
              corr <= '0;
              state <= S_OUT;
            end else begin
              yaw <= sample.yaw_rate_in;
              state <= S_SUB;
            end
          end
        end
        S_SUB: begin
          x <= ghp_pkg::sat32(66'(yaw) - 66'(cfg.rate_offset));
          acc <= '0;
          op <= OP_B0;
          state <= S_MUL;
        end
        S_MUL: begin
          state <= S_ACC;
        end
        S_ACC: begin
          op <= op + 4'd1;
          case (op)
            OP_A2: begin
              acc <= prod_sum;
              state <= S_FILT;
            end
            OP_HEAD: begin
              heading <= ghp_pkg::sat32(head_sum);
              state <= S_MUL;
            end
            OP_INTG: begin
              integ <= integ_sum[17:0];
              diff <= 33'(err) - 33'(last_err);
              last_err <= err;
              state <= S_MUL;
            end
            OP_KD: begin
              kd100 <= prod[30:0];
              acc <= '0;
              state <= S_MUL;
            end
            OP_D: begin
              acc <= prod_sum;
              state <= S_CORR;
            end
            default: begin
              acc <= prod_sum;
              state <= S_MUL;
            end
          endcase
        end
        S_FILT: begin
          h1 <= h0;
          h0 <= x;
          y1 <= y0;
          y0 <= ghp_pkg::sat32(filt_rnd);
          state <= S_MUL;
        end
        S_CORR: begin
          corr <= corr_rnd[14:0];
          state <= S_OUT;
        end
        S_OUT: begin
          if (!result_valid || !result_stall) begin
            result_valid <= 1'b1;
            result.correction <= corr;
            result.filtered_rate <= y0;
            result.heading_angle <= heading;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/gyro_heading_pid.sv =====
// Yaw-rate filter, heading integrator and PID steering corrector. A sample
// word is taken only while sample_stall is low; a process word then goes
// from acceptance to a result through offset subtract, eleven
// multiply-accumulate steps on one shared 33x33 multiplier, filter
// rounding, correction rounding and output, and a clear word goes straight
// to output. The next word is taken in the cycle after its
// result is loaded into the output register; while a result is held, one
// further word is taken and computed and then waits for the output
// register. Registers sit on an APB port at byte offsets
// 4*i and should be written only while the block is idle; issue a clear
// word after changing gains or mode.
module gyro_heading_pid (
  input  logic              clk,
  input  logic              rst,
  input  logic              sample_valid,
  output logic              sample_stall,
  input  ghp_pkg::sample_t  sample,
  output logic              result_valid,
  input  logic              result_stall,
  output ghp_pkg::result_t  result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  ghp_pkg::cfg_t cfg;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod;

  ghp_regs u_regs (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
  );

  ghp_mul u_mul (
    .clk(clk), .a(mul_a), .b(mul_b), .prod(prod)
  );

  ghp_core u_core (
    .clk(clk), .rst(rst), .cfg(cfg),
    .sample_valid(sample_valid), .sample_stall(sample_stall), .sample(sample),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .mul_a(mul_a), .mul_b(mul_b), .prod(prod)
  );

endmodule

// ===== hw/rtl/gyro_heading_pid_chk.sv =====
`include "gyro_heading_pid_assert.svh"

module gyro_heading_pid_chk (
  input logic              clk,
  input logic              rst,
  input logic              sample_valid,
  input logic              sample_stall,
  input ghp_pkg::result_t  result,
  input logic              result_valid,
  input logic              result_stall
);

  `GHP_ASSERT_NEXT(busy_after_accept, sample_valid && !sample_stall, sample_stall)
  `GHP_ASSERT_SAME(corr_in_range, result_valid, (result.correction <= 15'sd9830) && (result.correction >= -15'sd9830))
  `GHP_ASSERT_NEXT(result_held, result_valid && result_stall, result_valid && $stable(result))

endmodule

bind gyro_heading_pid gyro_heading_pid_chk u_chk (
  .clk(clk), .rst(rst), .sample_valid(sample_valid), .sample_stall(sample_stall),
  .result(result), .result_valid(result_valid), .result_stall(result_stall)
);

// ===== tb/gyro_heading_pid_test.sv =====
`timescale 1ns / 100ps

module gyro_heading_pid_test;

  logic clk;
  logic rst;
  logic sample_valid;
  logic sample_stall;
  ghp_pkg::sample_t sample;
  logic result_valid;
  logic result_stall;
  ghp_pkg::result_t result;
  logic psel;
  logic penable;
  logic pwrite;
  logic [4:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  gyro_heading_pid u_top (
    .clk(clk), .rst(rst),
    .sample_valid(sample_valid), .sample_stall(sample_stall), .sample(sample),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  localparam longint SAT_HI = 64'sd2147483647;
  localparam longint SAT_LO = -64'sd2147483648;
  localparam longint LIM_INTEG = ((3 << 16) + 5) / 10;
  localparam longint LIM_CORR = ((15 << 16) + 50) / 100;

  ghp_pkg::cfg_t gains;
  logic signed [31:0] hist_x [2];
  logic signed [31:0] hist_y [2];
  logic signed [31:0] heading_q;
  logic signed [31:0] integ_q;
  logic signed [31:0] prev_err;

  ghp_pkg::result_t pending_q [$];
  int errors;
  int burst_left;

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint rnd(longint v, int n);
    return (v + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  task automatic compute_correction(input ghp_pkg::sample_t s);
    ghp_pkg::result_t r;
    longint x, acc, err, kp, ki, kd, integ, deriv, corr;
    logic signed [31:0] y;
    corr = 0;
    if (s.action) begin
      heading_q = 0;
      integ_q = 0;
      prev_err = 0;
    end else begin
      x = clip(longint'(s.yaw_rate_in) - longint'(gains.rate_offset), SAT_LO, SAT_HI);
      acc = 5390989 * x + 10782247 * longint'(hist_x[0]) + 5390989 * longint'(hist_x[1])
          + 419032579 * longint'(hist_y[0]) - 172161617 * longint'(hist_y[1]);
      y = 32'(clip(rnd(acc, 28), SAT_LO, SAT_HI));
      hist_x[1] = hist_x[0];
      hist_x[0] = 32'(x);
      hist_y[1] = hist_y[0];
      hist_y[0] = y;
      heading_q = 32'(clip(longint'(heading_q) - rnd(longint'(y) * 749613, 32),
                           SAT_LO, SAT_HI));
      if (gains.lock_mode) begin
        err = clip(-longint'(heading_q), SAT_LO, SAT_HI);
        kp = gains.lock_kp;
        ki = gains.lock_ki;
        kd = 0;
      end else begin
        err = y;
        kp = gains.rate_kp;
        ki = gains.rate_ki;
        kd = gains.rate_kd;
      end
      integ = clip(longint'(integ_q) + rnd(err * 42949673, 32), -LIM_INTEG, LIM_INTEG);
      integ_q = 32'(integ);
      deriv = (err - longint'(prev_err)) * 100;
      prev_err = 32'(err);
      corr = clip(rnd(kp * err + ki * integ + kd * deriv, 16), -LIM_CORR, LIM_CORR);
    end
    r.correction = 15'(corr);
    r.filtered_rate = hist_y[0];
    r.heading_angle = heading_q;
    pending_q.push_back(r);
  endtask

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    #200ms;
    $display("gyro_heading_pid_test failed");
    $finish;
  end

  initial begin
    int cnt;
    result_stall = 0;
    cnt = 0;
    forever begin
      @(posedge clk);
      cnt++;
      if (cnt % 200 < 60) result_stall <= 0;
      else result_stall <= ($urandom_range(0, 3) == 0);
    end
  end

  always @(posedge clk) begin
    ghp_pkg::result_t e;
    if (!rst && result_valid && !result_stall) begin
      if (pending_q.size() == 0) begin
        $error("unexpected result word");
        errors++;
      end else begin
        e = pending_q.pop_front();
        if (result.correction !== e.correction) begin
          $error("correction exp %0d got %0d", e.correction, result.correction);
          errors++;
        end
        if (result.filtered_rate !== e.filtered_rate) begin
          $error("filtered_rate exp %0d got %0d", e.filtered_rate, result.filtered_rate);
          errors++;
        end
        if (result.heading_angle !== e.heading_angle) begin
          $error("heading_angle exp %0d got %0d", e.heading_angle, result.heading_angle);
          errors++;
        end
      end
    end
  end

  task automatic send_word(input logic act, input logic signed [31:0] rate);
    ghp_pkg::sample_t s;
    if (burst_left == 0) begin
      repeat ($urandom_range(1, 40)) @(posedge clk);
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    s.action = act;
    s.yaw_rate_in = rate;
    sample_valid <= 1;
    sample <= s;
    do @(posedge clk); while (sample_stall);
    compute_correction(s);
    if (burst_left == 0) sample_valid <= 0;
  endtask

  task automatic drain;
    int guard;
    if (burst_left != 0) sample_valid <= 0;
    guard = 0;
    while (pending_q.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (40) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    @(posedge clk);
    case (idx)
      ghp_pkg::REG_RATE_KP: gains.rate_kp = val[23:0];
      ghp_pkg::REG_RATE_KI: gains.rate_ki = val[23:0];
      ghp_pkg::REG_RATE_KD: gains.rate_kd = val[23:0];
      ghp_pkg::REG_LOCK_KP: gains.lock_kp = val[23:0];
      ghp_pkg::REG_LOCK_KI: gains.lock_ki = val[23:0];
      ghp_pkg::REG_RATE_OFFSET: gains.rate_offset = val;
      ghp_pkg::REG_LOCK_MODE: gains.lock_mode = val[0];
      default: ;
    endcase
  endtask

  task automatic set_gains(input logic [31:0] kp, ki, kd, lkp, lki, ofs,
                           input logic mode);
    write_reg(ghp_pkg::REG_RATE_KP, kp);
    write_reg(ghp_pkg::REG_RATE_KI, ki);
    write_reg(ghp_pkg::REG_RATE_KD, kd);
    write_reg(ghp_pkg::REG_LOCK_KP, lkp);
    write_reg(ghp_pkg::REG_LOCK_KI, lki);
    write_reg(ghp_pkg::REG_RATE_OFFSET, ofs);
    write_reg(ghp_pkg::REG_LOCK_MODE, {31'd0, mode});
  endtask

  function automatic logic [31:0] any_rate();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: return 32'($signed($urandom_range(0, 4000000)) - 2000000);
    endcase
  endfunction

  task automatic test_defaults;
    send_word(0, 32'sh7fffffff);
    send_word(0, 32'sh80000000);
    send_word(0, 0);
    send_word(1, 32'hffffffff);
    send_word(0, 32'sd65536);
    drain();
  endtask

  task automatic test_rate_extremes;
    set_gains(32'h7fffff, 32'h7fffff, 32'h7fffff, 32'h800000, 32'h800000,
              32'h7fffffff, 0);
    send_word(1, 0);
    send_word(0, 32'sh80000000);
    send_word(0, 32'sh80000000);
    send_word(0, 32'sh7fffffff);
    drain();
    write_reg(ghp_pkg::REG_RATE_OFFSET, 32'h80000000);
    send_word(0, 32'sh7fffffff);
    send_word(0, 32'sh7fffffff);
    send_word(0, 0);
    send_word(1, 0);
    drain();
  endtask

  task automatic test_lock_saturation;
    set_gains(32'h800000, 32'h800000, 32'h800000, 32'h7fffff, 32'h7fffff, 0, 1);
    send_word(1, 0);
    repeat (6) send_word(0, 32'sh7fffffff);
    repeat (6) send_word(0, 32'sh80000000);
    send_word(1, 0);
    drain();
  endtask

  task automatic test_random;
    repeat (10) begin
      set_gains($urandom, $urandom, $urandom, $urandom, $urandom,
                $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 200000),
                $urandom_range(0, 1));
      send_word(1, $urandom);
      repeat (100) send_word($urandom_range(0, 30) == 0, any_rate());
      drain();
    end
  endtask

  initial begin
    errors = 0;
    burst_left = 0;
    rst = 1;
    sample_valid = 0;
    sample = '0;
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = '0;
    pwdata = '0;
    gains = '0;
    gains.lock_kp = ghp_pkg::LOCK_KP_RESET;
    gains.lock_ki = ghp_pkg::LOCK_KI_RESET;
    hist_x[0] = 0;
    hist_x[1] = 0;
    hist_y[0] = 0;
    hist_y[1] = 0;
    heading_q = 0;
    integ_q = 0;
    prev_err = 0;
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_defaults();
    test_rate_extremes();
    test_lock_saturation();
    test_random();
    if (errors == 0 && pending_q.size() == 0) begin
      $display("gyro_heading_pid_test passed");
    end else begin
      $display("gyro_heading_pid_test failed");
    end
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/ghp_pkg.sv
hw/rtl/ghp_regs.sv
hw/rtl/ghp_mul.sv
hw/rtl/ghp_core.sv
hw/rtl/gyro_heading_pid.sv
hw/rtl/gyro_heading_pid_chk.sv
tb/gyro_heading_pid_test.sv
